>>> design/assert_macros.svh
// Assertion macros used by the RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Hold the property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Antecedent in this cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> design/bmh_pkg.sv
`default_nettype none

package bmh_pkg;

  localparam int TAG_BITS = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BINIT,
    ST_RDP,
    ST_RDL,
    ST_CMPL,
    ST_CMPR,
    ST_DEC,
    ST_DESC,
    ST_PUT,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic ld;         // store the accepted request, or flag it dropped when full
    logic init_b;     // build index to count/2-1, clear emit index
    logic rd_par;     // read node at build index, sift position to it
    logic take_mov;   // latch the moving entry from read data
    logic rst_best;   // best candidate back to moving entry
    logic rd_left;    // read left child of sift position
    logic rd_right;   // read right child of sift position
    logic cmp;        // compare read child against best
    logic wr_best;    // write best at sift position, descend
    logic wr_mov;     // write moving entry at sift position
    logic dec_b;      // step build index down
    logic rd_emit;    // read next entry for output
    logic done;       // clear count and drop flag
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic n_ge2;
    logic lc_ok;
    logic rc_ok;
    logic moved;
    logic b_zero;
    logic k_last;
  } sts_t;

endpackage

`default_nettype wire

>>> design/bmh_ram.sv
`default_nettype none

module bmh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/bmh_ctrl.sv
`default_nettype none

module bmh_ctrl
  import bmh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic in_is_last,
  input  wire sts_t sts,
  output logic      busy,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start && in_is_last) state_nxt = ST_BINIT;
      ST_BINIT: state_nxt = sts.n_ge2 ? ST_RDP : ST_EMIT;
      ST_RDP:   state_nxt = ST_RDL;
      ST_RDL:   state_nxt = sts.lc_ok ? ST_CMPL : ST_PUT;
      ST_CMPL:  state_nxt = sts.rc_ok ? ST_CMPR : ST_DEC;
      ST_CMPR:  state_nxt = ST_DEC;
      ST_DEC:   state_nxt = sts.moved ? ST_DESC : ST_PUT;
      ST_DESC:  state_nxt = sts.lc_ok ? ST_CMPL : ST_PUT;
      ST_PUT:   state_nxt = sts.b_zero ? ST_EMIT : ST_RDP;
      ST_EMIT:  if (sts.k_last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy   = 1'b0;
        cmd.ld = start;
      end
      ST_BINIT: cmd.init_b = 1'b1;
      ST_RDP:   cmd.rd_par = 1'b1;
      ST_RDL: begin
        cmd.take_mov = 1'b1;
        cmd.rd_left  = sts.lc_ok;
      end
      ST_CMPL: begin
        cmd.cmp      = 1'b1;
        cmd.rd_right = sts.rc_ok;
      end
      ST_CMPR:  cmd.cmp = 1'b1;
      ST_DEC:   cmd.wr_best = sts.moved;
      ST_DESC: begin
        cmd.rst_best = 1'b1;
        cmd.rd_left  = sts.lc_ok;
      end
      ST_PUT: begin
        cmd.wr_mov = 1'b1;
        cmd.dec_b  = !sts.b_zero;
      end
      ST_EMIT: begin
        cmd.rd_emit = 1'b1;
        cmd.done    = sts.k_last;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

>>> design/bmh_dp.sv
`default_nettype none

module bmh_dp
  import bmh_pkg::*;
#(
  parameter int MAX_ITEMS = 64,
  parameter int KEY_BITS  = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  input  wire logic [KEY_BITS-1:0] in_key,
  input  wire logic [TAG_BITS-1:0] in_tag,
  output sts_t                     sts,
  output logic                     out_strobe,
  output logic      [KEY_BITS-1:0] out_key_res,
  output logic      [TAG_BITS-1:0] out_tag_res,
  output logic                     out_is_last_res,
  output logic                     out_overflow
);

  localparam int AW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int CHW = AW + 2;
  localparam int EW  = KEY_BITS + TAG_BITS;

  logic [CW-1:0]  count_r;
  logic           dropped_r;
  logic [AW-1:0]  b_r;
  logic [AW-1:0]  s_r;
  logic [AW-1:0]  k_r;
  logic [AW-1:0]  cidx_r;
  logic [AW-1:0]  best_idx_r;
  logic [EW-1:0]  mov_r;
  logic [EW-1:0]  best_r;
  logic           moved_r;
  logic           strobe_r;
  logic           last_r;
  logic           ovf_r;

  logic           full;
  logic [CHW-1:0] lc;
  logic [CHW-1:0] rc;
  logic [CW-1:0]  half_m1;
  logic [CW-1:0]  k_inc;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [EW-1:0]  wr_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [EW-1:0]  rd_data;
  logic           child_less;

  assign full    = (count_r == CW'(MAX_ITEMS));
  assign lc      = {1'b0, s_r, 1'b1};
  assign rc      = {1'b0, s_r, 1'b0} + CHW'(2);
  assign half_m1 = (count_r >> 1) - CW'(1);
  assign k_inc   = CW'(k_r) + CW'(1);

  assign sts.n_ge2  = (count_r >= CW'(2));
  assign sts.lc_ok  = (lc < CHW'(count_r));
  assign sts.rc_ok  = (rc < CHW'(count_r));
  assign sts.moved  = moved_r;
  assign sts.b_zero = (b_r == '0);
  assign sts.k_last = (k_inc == count_r);

  // strictly smaller only: equal keys stay put
  assign child_less = (rd_data[EW-1:TAG_BITS] < best_r[EW-1:TAG_BITS]);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s_r;
    wr_data = mov_r;
    priority if (cmd.ld && !full) begin
      wr_en   = 1'b1;
      wr_addr = count_r[AW-1:0];
      wr_data = {in_key, in_tag};
    end else if (cmd.wr_best) begin
      wr_en   = 1'b1;
      wr_data = best_r;
    end else if (cmd.wr_mov) begin
      wr_en   = 1'b1;
    end
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = k_r;
    priority if (cmd.rd_par) begin
      rd_addr = b_r;
    end else if (cmd.rd_left) begin
      rd_addr = lc[AW-1:0];
    end else if (cmd.rd_right) begin
      rd_addr = rc[AW-1:0];
    end else if (cmd.rd_emit) begin
      rd_addr = k_r;
    end else begin
      rd_en = 1'b0;
    end
  end

  bmh_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ITEMS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
      b_r       <= '0;
      s_r       <= '0;
      k_r       <= '0;
      moved_r   <= 1'b0;
      strobe_r  <= 1'b0;
      last_r    <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      strobe_r <= cmd.rd_emit;
      last_r   <= cmd.rd_emit && sts.k_last;
      ovf_r    <= cmd.rd_emit && dropped_r;
      if (cmd.ld) begin
        if (full) begin
          dropped_r <= 1'b1;
        end else begin
          count_r <= count_r + CW'(1);
        end
      end
      if (cmd.init_b) begin
        b_r <= half_m1[AW-1:0];
        k_r <= '0;
      end
      if (cmd.dec_b) begin
        b_r <= b_r - AW'(1);
      end
      if (cmd.rd_par) begin
        s_r <= b_r;
      end
      if (cmd.take_mov || cmd.rst_best) begin
        moved_r <= 1'b0;
      end
      if (cmd.cmp && child_less) begin
        moved_r <= 1'b1;
      end
      if (cmd.wr_best) begin
        s_r <= best_idx_r;
      end
      if (cmd.rd_emit) begin
        k_r <= k_r + AW'(1);
      end
      if (cmd.done) begin
        count_r   <= '0;
        dropped_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_mov) begin
      mov_r  <= rd_data;
      best_r <= rd_data;
    end
    if (cmd.rst_best) begin
      best_r <= mov_r;
    end
    if (cmd.cmp && child_less) begin
      best_r     <= rd_data;
      best_idx_r <= cidx_r;
    end
    if (cmd.rd_left) begin
      cidx_r <= lc[AW-1:0];
    end else if (cmd.rd_right) begin
      cidx_r <= rc[AW-1:0];
    end
  end

  assign out_strobe      = strobe_r;
  assign out_key_res     = rd_data[EW-1:TAG_BITS];
  assign out_tag_res     = rd_data[TAG_BITS-1:0];
  assign out_is_last_res = last_r;
  assign out_overflow    = ovf_r;

endmodule

`default_nettype wire

>>> design/build_min_heap.sv
// Channel   Ports                                       Handshake
// request   in_key, in_tag, in_is_last                  start && !busy
// result    out_key_res, out_tag_res, out_is_last_res,  out_strobe, one cycle
//           out_overflow
//
// While loading, busy stays low and requests are taken back to back. The build
// then does a setup step and, per node, a fetch, a compare with the children,
// a move and a new compare per level it sinks, and a store. Emission reads one
// entry per cycle; results follow back to back after the build; the receiver
// cannot stall them. busy stays high from the last request until the final read.
// Synchronous active-low reset clears control; RAM contents are not cleared.
`default_nettype none

module build_min_heap
  import bmh_pkg::*;
#(
  parameter int MAX_ITEMS = 64,
  parameter int KEY_BITS  = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [KEY_BITS-1:0] in_key,
  input  wire logic [TAG_BITS-1:0] in_tag,
  input  wire logic                in_is_last,
  output logic                     out_strobe,
  output logic      [KEY_BITS-1:0] out_key_res,
  output logic      [TAG_BITS-1:0] out_tag_res,
  output logic                     out_is_last_res,
  output logic                     out_overflow
);

`include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;

  bmh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_is_last (in_is_last),
    .sts        (sts),
    .busy       (busy),
    .cmd        (cmd)
  );

  bmh_dp #(
    .MAX_ITEMS (MAX_ITEMS),
    .KEY_BITS  (KEY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_key          (in_key),
    .in_tag          (in_tag),
    .sts             (sts),
    .out_strobe      (out_strobe),
    .out_key_res     (out_key_res),
    .out_tag_res     (out_tag_res),
    .out_is_last_res (out_is_last_res),
    .out_overflow    (out_overflow)
  );

  `ASSERT_NEXT(a_last_req_busy, clk, rst_n, start && !busy && in_is_last, busy)
  `ASSERT_ALWAYS(a_res_after_busy, clk, rst_n, !out_strobe || $past(busy))
  `ASSERT_ALWAYS(a_last_has_strobe, clk, rst_n, !out_is_last_res || out_strobe)
  `ASSERT_NEXT(a_final_ends_batch, clk, rst_n, out_strobe && out_is_last_res, !out_strobe)

endmodule

`default_nettype wire

>>> bench/build_min_heap_test.sv
`timescale 1ns / 100ps

module build_min_heap_test;
  import bmh_pkg::*;

  localparam int KEY_W = 16;
  localparam int CAPACITY = 64;
  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [TAG_BITS-1:0] tag;
  } heap_entry_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [TAG_BITS-1:0] tag;
    logic                last;
    logic                ovf;
  } heap_slot_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [KEY_W-1:0]    in_key = '0;
  logic [TAG_BITS-1:0] in_tag = '0;
  logic                in_is_last = 1'b0;
  logic                out_strobe;
  logic [KEY_W-1:0]    out_key_res;
  logic [TAG_BITS-1:0] out_tag_res;
  logic                out_is_last_res;
  logic                out_overflow;

  heap_entry_t batch_store [CAPACITY];
  int          batch_count = 0;
  bit          batch_dropped = 1'b0;
  heap_slot_t  heap_order_q [$];

  int errors = 0;
  int items_sent = 0;
  int batches_built = 0;
  int overflow_batches = 0;
  int results_seen = 0;
  int cycle_cnt = 0;
  bit no_gap = 1'b0;

  build_min_heap #(.MAX_ITEMS(CAPACITY), .KEY_BITS(KEY_W)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_key(in_key),
    .in_tag(in_tag),
    .in_is_last(in_is_last),
    .out_strobe(out_strobe),
    .out_key_res(out_key_res),
    .out_tag_res(out_tag_res),
    .out_is_last_res(out_is_last_res),
    .out_overflow(out_overflow)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               heap_order_q.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int expected_val, int got_val);
    errors++;
    $display("mismatch at cycle %0d: %s expected %0h got %0h", cycle_cnt, what,
             expected_val, got_val);
  endtask

  // Sink one node: a child wins only when strictly smaller, left tried first.
  function automatic void sift_down_node(int n, int node);
    int pos;
    int best;
    int lc;
    int rc;
    heap_entry_t tmp;
    pos = node;
    while (1) begin
      best = pos;
      lc = 2 * pos + 1;
      rc = 2 * pos + 2;
      if (lc < n && batch_store[lc].key < batch_store[best].key) best = lc;
      if (rc < n && batch_store[rc].key < batch_store[best].key) best = rc;
      if (best == pos) break;
      tmp = batch_store[pos];
      batch_store[pos] = batch_store[best];
      batch_store[best] = tmp;
      pos = best;
    end
  endfunction

  function automatic void accept_element(logic [KEY_W-1:0] key, logic [TAG_BITS-1:0] tag,
                                         logic last);
    heap_slot_t slot;
    if (batch_count < CAPACITY) begin
      batch_store[batch_count].key = key;
      batch_store[batch_count].tag = tag;
      batch_count++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (last) begin
      for (int i = batch_count / 2; i > 0; i--) sift_down_node(batch_count, i - 1);
      for (int k = 0; k < batch_count; k++) begin
        slot.key = batch_store[k].key;
        slot.tag = batch_store[k].tag;
        slot.last = (k == batch_count - 1);
        slot.ovf = batch_dropped;
        heap_order_q.push_back(slot);
      end
      batches_built++;
      if (batch_dropped) overflow_batches++;
      batch_count = 0;
      batch_dropped = 1'b0;
    end
  endfunction

  // Hold start low for a random gap, then raise it until the request is taken.
  task automatic send_request(logic [KEY_W-1:0] key, logic [TAG_BITS-1:0] tag, logic last);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      in_key <= KEY_W'($urandom);
      in_tag <= TAG_BITS'($urandom);
      in_is_last <= 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_key <= key;
    in_tag <= tag;
    in_is_last <= last;
    do @(posedge clk); while (busy);
    items_sent++;
    accept_element(key, tag, last);
  endtask

  task automatic send_batch(int n, bit narrow_keys);
    logic [KEY_W-1:0] key;
    for (int i = 0; i < n; i++) begin
      key = narrow_keys ? KEY_W'($urandom_range(0, 7)) : KEY_W'($urandom);
      send_request(key, TAG_BITS'($urandom), i == n - 1);
    end
  endtask

  always @(posedge clk) begin
    heap_slot_t want;
    if (rst_n && out_strobe === 1'b1) begin
      results_seen++;
      if (heap_order_q.size() == 0) begin
        report_mismatch("unexpected result, key", 0, int'(out_key_res));
      end else begin
        want = heap_order_q.pop_front();
        if (out_key_res !== want.key)
          report_mismatch("key_res", int'(want.key), int'(out_key_res));
        if (out_tag_res !== want.tag)
          report_mismatch("tag_res", int'(want.tag), int'(out_tag_res));
        if (out_is_last_res !== want.last)
          report_mismatch("is_last_res", int'(want.last), int'(out_is_last_res));
        if (out_overflow !== want.ovf)
          report_mismatch("overflow", int'(want.ovf), int'(out_overflow));
      end
    end
  end

  task automatic test_single_element();
    send_request(16'hFFFF, 8'hFF, 1'b1);
  endtask

  task automatic test_key_extremes();
    send_request(16'hFFFF, 8'h00, 1'b0);
    send_request(16'h8000, 8'hFF, 1'b0);
    send_request(16'h7FFF, 8'hAA, 1'b0);
    send_request(16'h0001, 8'h55, 1'b0);
    send_request(16'h0000, 8'h0F, 1'b1);
  endtask

  // Equal keys never move.
  task automatic test_equal_keys();
    for (int i = 0; i < 5; i++) send_request(16'h1234, TAG_BITS'(i + 1), i == 4);
  endtask

  task automatic test_sibling_ties();
    send_request(16'd9, 8'h10, 1'b0);
    send_request(16'd3, 8'h11, 1'b0);
    send_request(16'd3, 8'h12, 1'b1);
    send_request(16'd9, 8'h20, 1'b0);
    send_request(16'd5, 8'h21, 1'b0);
    send_request(16'd3, 8'h22, 1'b1);
  endtask

  task automatic test_descending_keys();
    for (int i = 0; i < 7; i++) send_request(KEY_W'(70 - 10 * i), TAG_BITS'(i), i == 6);
  endtask

  // Fill the store exactly, then overrun it so that the last request is dropped too.
  task automatic test_capacity();
    send_batch(CAPACITY, 1'b0);
    no_gap = 1'b1;
    send_batch(CAPACITY + 3, 1'b1);
    no_gap = 1'b0;
  endtask

  task automatic test_random_batches();
    int pick;
    int n;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) n = $urandom_range(CAPACITY, CAPACITY + 6);
      else if (pick == 1) n = $urandom_range(13, CAPACITY - 1);
      else n = $urandom_range(1, 12);
      no_gap = ($urandom_range(0, 3) == 0);
      send_batch(n, 1'($urandom_range(0, 1)));
    end
    no_gap = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_element();
    test_key_extremes();
    test_equal_keys();
    test_sibling_ties();
    test_descending_keys();
    test_capacity();
    test_random_batches();

    @(negedge clk);
    start <= 1'b0;
    while (heap_order_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d requests in %0d batches, %0d of them overrun the store",
             items_sent, batches_built, overflow_batches);
    $display("checked %0d heap entries, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/bmh_pkg.sv
design/bmh_ram.sv
design/bmh_ctrl.sv
design/bmh_dp.sv
design/build_min_heap.sv
bench/build_min_heap_test.sv
